@@ sv/rv64i_base_integer_execute_top_assert.svh @@
// Assertion macros shared by the execute unit.
`ifndef RV64I_BASE_INTEGER_EXECUTE_TOP_ASSERT_SVH
`define RV64I_BASE_INTEGER_EXECUTE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define RV64IE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rv64ie assertion failed");
`define RV64IE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rv64ie assertion failed");
`else
`define RV64IE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RV64IE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/rv64ie_pkg.sv @@
package rv64ie_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int ROW_AW    = MEM_AW - 2;
    localparam int MEM_ROWS  = MEM_BYTES / 4;

    localparam int IN_W  = 40;
    localparam int OUT_W = 152;

    typedef enum logic [5:0] {
        OP_LUI   = 6'd0,  OP_AUIPC = 6'd1,  OP_JAL   = 6'd2,  OP_JALR  = 6'd3,
        OP_BEQ   = 6'd4,  OP_BNE   = 6'd5,  OP_BLT   = 6'd6,  OP_BGE   = 6'd7,
        OP_BLTU  = 6'd8,  OP_BGEU  = 6'd9,  OP_SB    = 6'd10, OP_SH    = 6'd11,
        OP_SW    = 6'd12, OP_LB    = 6'd13, OP_LH    = 6'd14, OP_LW    = 6'd15,
        OP_LBU   = 6'd16, OP_LHU   = 6'd17, OP_ADDI  = 6'd18, OP_SLTI  = 6'd19,
        OP_SLTIU = 6'd20, OP_XORI  = 6'd21, OP_ORI   = 6'd22, OP_ANDI  = 6'd23,
        OP_SLLI  = 6'd24, OP_SRLI  = 6'd25, OP_SRAI  = 6'd26, OP_ADD   = 6'd27,
        OP_SUB   = 6'd28, OP_SLL   = 6'd29, OP_SLT   = 6'd30, OP_SLTU  = 6'd31,
        OP_XOR   = 6'd32, OP_SRL   = 6'd33, OP_SRA   = 6'd34, OP_OR    = 6'd35,
        OP_AND   = 6'd36
    } op_t;

    // Result of the execute stage for one instruction.
    typedef struct packed {
        logic              ok;
        logic [63:0]       next_pc;
        logic              wr;
        logic [4:0]        rd;
        logic [63:0]       val;
        logic              st;
        logic              ld;
        logic              mem;
        logic [MEM_AW-1:0] base;
        op_t               op;
        logic [31:0]       stdata;
    } ex_t;

    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [63:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [MEM_AW-1:0] addr;
        logic [2:0]        nbytes;
        logic [31:0]       wdata;
    } dm_req_t;

    function automatic logic [2:0] access_bytes(input op_t op);
        logic [2:0] n;
        case (op) inside
            OP_SB, OP_LB, OP_LBU: n = 3'd1;
            OP_SH, OP_LH, OP_LHU: n = 3'd2;
            default:              n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

@@ sv/rv64i_base_integer_execute_top.sv @@
// Channel   Dir  Width  Contents (low bit up)
// s_*       in   40     operation[5:0], instruction_word[37:6], zero pad
// m_*       out  152    status, next_pc, reg_write, reg_index, reg_value,
//                       mem_store, mem_address
//
// One instruction per cycle unless stalled: accept into the execute register,
// pass through the memory stage, land in the output register.
// A load holds off the next instruction until its data from
// the byte-banked data memory reaches the register file.
// After reset the data memory is zeroed one row a cycle: s_tready stays low
// until all MEM_BYTES/4 rows (16384) are zeroed.
// Each stage advances when the one after it is empty or advancing.
`include "rv64i_base_integer_execute_top_assert.svh"

module rv64i_base_integer_execute_top
    import rv64ie_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // operation, instruction_word
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, next_pc, reg_write, reg_index,
                                        // reg_value, mem_store, mem_address
);

    // Execute stage
    logic        e_valid_reg;
    op_t         e_op_reg;
    logic [31:0] e_word_reg;
    logic [63:0] pc_reg;
    logic [63:0] rf_a, rf_b;
    ex_t         ex;

    // Memory stage
    logic        m_valid_reg;
    ex_t         m_res_reg;
    logic [31:0] ld_word;
    logic [63:0] m_val;

    // Output stage
    logic             o_valid_reg;
    logic [OUT_W-1:0] o_data_reg;

    logic    s_acc, e_en, m_en, o_en, e_adv, m_adv, clr_busy;
    rf_wr_t  rf_wr;
    dm_req_t dm_req;

    assign o_en  = !o_valid_reg || m_tready;
    assign m_en  = !m_valid_reg || o_en;
    assign e_en  = !e_valid_reg || m_en;
    assign e_adv = e_valid_reg && m_en;
    assign m_adv = m_valid_reg && o_en;

    // Hold off input while memory is cleared, on a stall, or when it could read a load result not yet written.
    assign s_tready = e_en && !clr_busy
                      && !(e_valid_reg && ex.ld)
                      && !(m_valid_reg && m_res_reg.ld && !o_en);
    assign s_acc = s_tvalid && s_tready;

    rv64ie_regfile u_rf
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .re     (s_acc),
        .raddr1 (s_tdata[25:21]),
        .raddr2 (s_tdata[30:26]),
        .wr     (rf_wr),
        .rdata1 (rf_a),
        .rdata2 (rf_b)
    );

    rv64ie_alu u_alu
    (
        .op   (e_op_reg),
        .word (e_word_reg),
        .a    (rf_a),
        .b    (rf_b),
        .pc   (pc_reg),
        .res  (ex)
    );

    always_comb
    begin
        dm_req.we     = e_adv && ex.st;
        dm_req.re     = e_adv && ex.ld;
        dm_req.addr   = ex.base;
        dm_req.nbytes = access_bytes(ex.op);
        dm_req.wdata  = ex.stdata;
    end

    rv64ie_dmem u_dmem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dm_req),
        .busy  (clr_busy),
        .rdata (ld_word)
    );

    // Extend load data by access kind.
    always_comb
    begin
        case (m_res_reg.op)
            OP_LB:   m_val = {{56{ld_word[7]}}, ld_word[7:0]};
            OP_LH:   m_val = {{48{ld_word[15]}}, ld_word[15:0]};
            OP_LW:   m_val = {{32{ld_word[31]}}, ld_word};
            OP_LBU:  m_val = {56'd0, ld_word[7:0]};
            OP_LHU:  m_val = {48'd0, ld_word[15:0]};
            default: m_val = m_res_reg.val;
        endcase
        if (!m_res_reg.wr)
            m_val = 64'd0;
    end

    // Non-loads write back leaving execute, loads leaving the memory stage;
    // the load stall keeps the two from meeting on one edge.
    always_comb
    begin
        if (m_adv && m_res_reg.ld)
        begin
            rf_wr.we   = m_res_reg.wr;
            rf_wr.addr = m_res_reg.rd;
            rf_wr.data = m_val;
        end
        else
        begin
            rf_wr.we   = e_adv && ex.wr && !ex.ld;
            rf_wr.addr = ex.rd;
            rf_wr.data = ex.val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            pc_reg      <= 64'd0;
        end
        else
        begin
            if (e_en)
                e_valid_reg <= s_acc;
            if (m_en)
                m_valid_reg <= e_valid_reg;
            if (o_en)
                o_valid_reg <= m_valid_reg;
            if (e_adv)
                pc_reg <= ex.next_pc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            e_op_reg   <= op_t'(s_tdata[5:0]);
            e_word_reg <= s_tdata[37:6];
        end
        if (e_adv)
            m_res_reg <= ex;
        if (m_adv)
            o_data_reg <= {16'(32'(m_res_reg.base)), m_res_reg.st, m_val,
                           m_res_reg.rd, m_res_reg.wr, m_res_reg.next_pc,
                           !m_res_reg.ok};
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;

    `RV64IE_ASSERT_IMP(a_no_accept_clearing, clk, rst_n, clr_busy, !s_tready)
    `RV64IE_ASSERT_IMP(a_load_use_hold, clk, rst_n, e_valid_reg && ex.ld, !s_tready)
    `RV64IE_ASSERT_IMP(a_no_x0_write, clk, rst_n, rf_wr.we, rf_wr.addr != 5'd0)
    `RV64IE_ASSERT_IMP(a_fail_no_effect, clk, rst_n, m_tvalid && m_tdata[0], !m_tdata[65] && !m_tdata[135])
    `RV64IE_ASSERT_NXT(a_load_moves_on, clk, rst_n, e_adv && ex.ld, m_valid_reg && m_res_reg.ld)

endmodule

@@ sv/rv64ie_regfile.sv @@
module rv64ie_regfile
    import rv64ie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        re,
    input  logic [4:0]  raddr1,
    input  logic [4:0]  raddr2,
    input  rf_wr_t      wr,
    output logic [63:0] rdata1,
    output logic [63:0] rdata2
);

    logic [63:0] mem [32];
    logic [31:0] vld_reg;
    logic [63:0] rdata1_reg;
    logic [63:0] rdata2_reg;
    logic [63:0] rd1_next;
    logic [63:0] rd2_next;

    // Pass through a write landing on the same edge.
    always_comb
    begin
        if (wr.we && wr.addr == raddr1)
            rd1_next = wr.data;
        else
            rd1_next = vld_reg[raddr1] ? mem[raddr1] : 64'd0;
        if (wr.we && wr.addr == raddr2)
            rd2_next = wr.data;
        else
            rd2_next = vld_reg[raddr2] ? mem[raddr2] : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (wr.we)
            vld_reg[wr.addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
            mem[wr.addr] <= wr.data;
        if (re)
        begin
            rdata1_reg <= rd1_next;
            rdata2_reg <= rd2_next;
        end
    end

    assign rdata1 = rdata1_reg;
    assign rdata2 = rdata2_reg;

endmodule

@@ sv/rv64ie_dmem.sv @@
module rv64ie_dmem
    import rv64ie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dm_req_t     req,
    output logic        busy,
    output logic [31:0] rdata
);

    logic              clr_busy_reg;
    logic [ROW_AW-1:0] clr_row_reg;
    logic [1:0]        bank_q_reg;
    logic [7:0]        rd_q [4];
    logic [1:0]        base_bank;
    logic [ROW_AW-1:0] base_row;

    assign base_bank = req.addr[1:0];
    assign base_row  = req.addr[MEM_AW-1:2];

    // Zero every row after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_AW'(MEM_ROWS - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
            bank_q_reg <= base_bank;
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [7:0]        mem [MEM_ROWS];
        logic [1:0]        rel;
        logic [ROW_AW-1:0] row;
        logic              en;
        logic [7:0]        wbyte;

        assign rel   = 2'(k) - base_bank;
        assign row   = base_row + ROW_AW'(2'(k) < base_bank);
        assign en    = {1'b0, rel} < req.nbytes;
        assign wbyte = req.wdata[8*rel +: 8];

        always_ff @(posedge clk)
        begin
            if (clr_busy_reg)
                mem[clr_row_reg] <= 8'd0;
            else if (req.we && en)
                mem[row] <= wbyte;
            if (req.re)
                rd_q[k] <= mem[row];
        end
    end

    // Rotate bank bytes back into access order.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            rdata[8*i +: 8] = rd_q[2'(bank_q_reg + 2'(i))];
    end

    assign busy = clr_busy_reg;

endmodule

@@ sv/rv64ie_alu.sv @@
module rv64ie_alu
    import rv64ie_pkg::*;
(
    input  op_t         op,
    input  logic [31:0] word,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [63:0] pc,
    output ex_t         res
);

    logic [63:0] imm_i, imm_s, imm_b, imm_u, imm_j;
    logic [63:0] val, next, sum_mem;
    logic        wr, st, ld, ok, take;
    logic [4:0]  rd;
    logic [5:0]  shamt_i, shamt_r;

    assign rd    = word[11:7];
    assign imm_i = {{52{word[31]}}, word[31:20]};
    assign imm_s = {{52{word[31]}}, word[31:25], word[11:7]};
    assign imm_b = {{52{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
    assign imm_u = {{32{word[31]}}, word[31:12], 12'd0};
    assign imm_j = {{44{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
    assign shamt_i = word[25:20];
    assign shamt_r = b[5:0];

    always_comb
    begin
        val  = 64'd0;
        next = pc + 64'd4;
        wr   = 1'b0;
        st   = 1'b0;
        ld   = 1'b0;
        ok   = 1'b1;
        take = 1'b0;
        unique case (op)
            OP_LUI:   begin val = imm_u; wr = 1'b1; end
            OP_AUIPC: begin val = pc + imm_u; wr = 1'b1; end
            OP_JAL:   begin val = pc + 64'd4; wr = 1'b1; next = pc + imm_j; end
            OP_JALR:
            begin
                val  = pc + 64'd4;
                wr   = 1'b1;
                next = (a + imm_i) & ~64'd1;
            end
            OP_BEQ:   take = (a == b);
            OP_BNE:   take = (a != b);
            OP_BLT:   take = ($signed(a) < $signed(b));
            OP_BGE:   take = !($signed(a) < $signed(b));
            OP_BLTU:  take = (a < b);
            OP_BGEU:  take = (a >= b);
            OP_SB, OP_SH, OP_SW: st = 1'b1;
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
            begin
                ld = 1'b1;
                wr = 1'b1;
            end
            OP_ADDI:  begin val = a + imm_i; wr = 1'b1; end
            OP_SLTI:  begin val = {63'd0, $signed(a) < $signed(imm_i)}; wr = 1'b1; end
            OP_SLTIU: begin val = {63'd0, a < imm_i}; wr = 1'b1; end
            OP_XORI:  begin val = a ^ imm_i; wr = 1'b1; end
            OP_ORI:   begin val = a | imm_i; wr = 1'b1; end
            OP_ANDI:  begin val = a & imm_i; wr = 1'b1; end
            OP_SLLI:  begin val = a << shamt_i; wr = 1'b1; end
            OP_SRLI:  begin val = a >> shamt_i; wr = 1'b1; end
            OP_SRAI:  begin val = 64'($signed(a) >>> shamt_i); wr = 1'b1; end
            OP_ADD:   begin val = a + b; wr = 1'b1; end
            OP_SUB:   begin val = a - b; wr = 1'b1; end
            OP_SLL:   begin val = a << shamt_r; wr = 1'b1; end
            OP_SLT:   begin val = {63'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
            OP_SLTU:  begin val = {63'd0, a < b}; wr = 1'b1; end
            OP_XOR:   begin val = a ^ b; wr = 1'b1; end
            OP_SRL:   begin val = a >> shamt_r; wr = 1'b1; end
            OP_SRA:   begin val = 64'($signed(a) >>> shamt_r); wr = 1'b1; end
            OP_OR:    begin val = a | b; wr = 1'b1; end
            OP_AND:   begin val = a & b; wr = 1'b1; end
            default:  ok = 1'b0;
        endcase
        if (take)
            next = pc + imm_b;
        if (!ok)
            next = pc;
        if (rd == 5'd0)
            wr = 1'b0;
    end

    assign sum_mem = a + (st ? imm_s : imm_i);

    always_comb
    begin
        res         = '0;
        res.ok      = ok;
        res.next_pc = next;
        res.wr      = wr;
        res.rd      = wr ? rd : 5'd0;
        res.val     = (wr && !ld) ? val : 64'd0;
        res.st      = st;
        res.ld      = ld;
        res.mem     = st || ld;
        res.base    = (st || ld) ? sum_mem[MEM_AW-1:0] : '0;
        res.op      = op;
        res.stdata  = b[31:0];
    end

endmodule
